FILE: src/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types, constants and width helpers for the rational arithmetic
// reduction block.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_WIDTH         = 33;
  localparam int RAW_MAX           = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INC = 3'd5,
    OP_DEC = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FORM,
    S_CHECK,
    S_REDUCE,
    S_FINISH
  } top_state_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_GCD,
    R_DIV
  } red_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } red_stat_t;

  // Width of the raw numerator/denominator: products plus one carry bit,
  // capped at 64 bits for the widest operands.
  function automatic int raw_width(input int w);
    return (2 * w + 1 > RAW_MAX) ? RAW_MAX : 2 * w + 1;
  endfunction

endpackage

FILE: src/rar_reduce.sv
// ----------------------------------------------------------------------------
// rar_reduce
// Divides a signed numerator/denominator pair by the gcd of their magnitudes.
// Binary gcd, one subtract/shift step per cycle, then a two-lane restoring
// divider sharing the gcd as divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rar_reduce #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 start,
  input  logic signed [rar_pkg::raw_width(OPERAND_WIDTH)-1:0]  raw_num,
  input  logic signed [rar_pkg::raw_width(OPERAND_WIDTH)-1:0]  raw_den,
  output logic signed [rar_pkg::raw_width(OPERAND_WIDTH)-1:0]  q_num,
  output logic signed [rar_pkg::raw_width(OPERAND_WIDTH)-1:0]  q_den,
  output rar_pkg::red_stat_t                                   stat
);
  import rar_pkg::*;

  localparam int RAW_W = raw_width(OPERAND_WIDTH);
  localparam int CW    = $clog2(RAW_W);

  red_state_t        state_r, state_nxt;
  logic [RAW_W-1:0]  x_r, x_nxt, y_r, y_nxt, g_r, g_nxt;
  logic [RAW_W-1:0]  a_r, a_nxt, b_r, b_nxt, ra_r, ra_nxt, rb_r, rb_nxt;
  logic [CW-1:0]     k_r, k_nxt, cnt_r, cnt_nxt;
  logic              neg_n_r, neg_n_nxt, neg_d_r, neg_d_nxt;
  logic              done_r, done_nxt;

  logic [RAW_W-1:0]  mag_n, mag_d;
  logic [RAW_W:0]    ta, tb, sa, sb, gx;
  logic              ga, gb;

  assign mag_n = raw_num[RAW_W-1] ? (~raw_num + 1'b1) : raw_num;
  assign mag_d = raw_den[RAW_W-1] ? (~raw_den + 1'b1) : raw_den;

  // divider lanes: shift in next dividend bit, subtract divisor if it fits
  assign gx = {1'b0, g_r};
  assign ta = {ra_r, a_r[RAW_W-1]};
  assign tb = {rb_r, b_r[RAW_W-1]};
  assign sa = ta - gx;
  assign sb = tb - gx;
  assign ga = (ta >= gx);
  assign gb = (tb >= gx);

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    g_nxt     = g_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    neg_n_nxt = neg_n_r;
    neg_d_nxt = neg_d_r;
    done_nxt  = 1'b0;
    case (state_r)
      R_IDLE: begin
        if (start) begin
          x_nxt     = mag_n;
          y_nxt     = mag_d;
          a_nxt     = mag_n;
          b_nxt     = mag_d;
          k_nxt     = '0;
          neg_n_nxt = raw_num[RAW_W-1];
          neg_d_nxt = raw_den[RAW_W-1];
          state_nxt = R_GCD;
        end
      end
      R_GCD: begin
        if (x_r == '0 || y_r == '0) begin
          g_nxt     = (x_r | y_r) << k_r;
          ra_nxt    = '0;
          rb_nxt    = '0;
          cnt_nxt   = CW'(RAW_W - 1);
          state_nxt = R_DIV;
        end else begin
          case ({x_r[0], y_r[0]})
            2'b00: begin
              x_nxt = x_r >> 1;
              y_nxt = y_r >> 1;
              k_nxt = k_r + 1'b1;
            end
            2'b01:   x_nxt = x_r >> 1;
            2'b10:   y_nxt = y_r >> 1;
            default: begin
              // both odd: difference is even, halve it right away
              if (x_r >= y_r) begin
                x_nxt = (x_r - y_r) >> 1;
              end else begin
                y_nxt = (y_r - x_r) >> 1;
              end
            end
          endcase
        end
      end
      R_DIV: begin
        ra_nxt = ga ? sa[RAW_W-1:0] : ta[RAW_W-1:0];
        rb_nxt = gb ? sb[RAW_W-1:0] : tb[RAW_W-1:0];
        a_nxt  = {a_r[RAW_W-2:0], ga};
        b_nxt  = {b_r[RAW_W-2:0], gb};
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = R_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    g_r     <= g_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    k_r     <= k_nxt;
    cnt_r   <= cnt_nxt;
    neg_n_r <= neg_n_nxt;
    neg_d_r <= neg_d_nxt;
  end

  assign q_num     = neg_n_r ? -$signed(a_r) : $signed(a_r);
  assign q_den     = neg_d_r ? -$signed(b_r) : $signed(b_r);
  assign stat.busy = (state_r != R_IDLE);
  assign stat.done = done_r;

endmodule

FILE: src/rational_arith_reduce.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Signed fraction add/sub/mul/div/negate/increment/decrement with the result
// reduced by the gcd of numerator and denominator magnitudes.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid/in_ready    in_op, in_num_a, in_den_a,
//                                             in_num_b, in_den_b
//   out_      output     out_valid/out_ready  out_res_num, out_res_den,
//                                             out_degenerate
//
// One transaction at a time; in_ready is high only while the sequencer idles.
// Raw forms use one shared multiplier (unary ops form them directly, without it).
// A zero raw part skips the reduction and yields 0/0 with out_degenerate set.
// Otherwise the gcd loop, the divider and a done step follow; RAW = 33 at
// 16-bit operands. Synchronous reset. A finished result waits in the output
// register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            in_op,
  input  logic signed [OPERAND_WIDTH-1:0]       in_num_a,
  input  logic signed [OPERAND_WIDTH-1:0]       in_den_a,
  input  logic signed [OPERAND_WIDTH-1:0]       in_num_b,
  input  logic signed [OPERAND_WIDTH-1:0]       in_den_b,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rar_pkg::RES_WIDTH-1:0]  out_res_num,
  output logic signed [rar_pkg::RES_WIDTH-1:0]  out_res_den,
  output logic                                  out_degenerate
);
  import rar_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int RAW_W = raw_width(OPERAND_WIDTH);

  top_state_t               state_r, state_nxt;
  op_t                      op_r;
  logic signed [W-1:0]      na_r, da_r, nb_r, db_r;
  logic [1:0]               mcnt_r, mcnt_nxt;
  logic signed [2*W-1:0]    prod_r, mprod;
  logic signed [W-1:0]      ma, mb;
  logic signed [RAW_W-1:0]  num_r, num_nxt, den_r, den_nxt;
  logic                     deg_r, deg_nxt;
  logic                     out_valid_r, out_valid_nxt, load_out;
  logic signed [RES_WIDTH-1:0] out_num_r, out_den_r;
  logic                     out_deg_r;

  logic                     in_acc;
  logic                     red_start;
  red_stat_t                red_stat;
  logic signed [RAW_W-1:0]  red_q_num, red_q_den;
  logic signed [63:0]       qn_wide, qd_wide;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // shared multiplier, operands picked by step
  always_comb begin
    case (mcnt_r)
      2'd0: begin
        ma = na_r;
        mb = (op_r == OP_MUL) ? nb_r : db_r;
      end
      2'd1: begin
        ma = nb_r;
        mb = da_r;
      end
      default: begin
        ma = da_r;
        mb = (op_r == OP_DIV) ? nb_r : db_r;
      end
    endcase
  end

  assign mprod = ma * mb;

  rar_reduce #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (red_start),
    .raw_num (num_r),
    .raw_den (den_r),
    .q_num   (red_q_num),
    .q_den   (red_q_den),
    .stat    (red_stat)
  );

  assign qn_wide = 64'(red_q_num);
  assign qd_wide = 64'(red_q_den);

  always_comb begin
    state_nxt     = state_r;
    mcnt_nxt      = mcnt_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    deg_nxt       = deg_r;
    red_start     = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        mcnt_nxt = '0;
        if (in_acc) begin
          if (op_t'(in_op) inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_FORM;
          end
        end
      end
      S_MUL: begin
        mcnt_nxt = mcnt_r + 1'b1;
        case (mcnt_r)
          2'd0: ;
          2'd1: num_nxt = RAW_W'(prod_r);
          2'd2: begin
            if (op_r == OP_ADD) begin
              num_nxt = num_r + RAW_W'(prod_r);
            end else if (op_r == OP_SUB) begin
              num_nxt = num_r - RAW_W'(prod_r);
            end
          end
          default: begin
            den_nxt   = RAW_W'(prod_r);
            state_nxt = S_CHECK;
          end
        endcase
      end
      S_FORM: begin
        den_nxt = RAW_W'(da_r);
        case (op_r)
          OP_NEG:  num_nxt = -RAW_W'(na_r);
          OP_INC:  num_nxt = RAW_W'(na_r) + RAW_W'(da_r);
          OP_DEC:  num_nxt = RAW_W'(na_r) - RAW_W'(da_r);
          default: begin
            // unused code: 0/0
            num_nxt = '0;
            den_nxt = '0;
          end
        endcase
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (num_r == '0 || den_r == '0) begin
          deg_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          deg_nxt   = 1'b0;
          red_start = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (red_stat.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= op_t'(in_op);
      na_r <= in_num_a;
      da_r <= in_den_a;
      nb_r <= in_num_b;
      db_r <= in_den_b;
    end
    if (state_r == S_MUL) begin
      prod_r <= mprod;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    deg_r <= deg_nxt;
    if (load_out) begin
      out_num_r <= deg_r ? '0 : qn_wide[RES_WIDTH-1:0];
      out_den_r <= deg_r ? '0 : qd_wide[RES_WIDTH-1:0];
      out_deg_r <= deg_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_res_num    = out_num_r;
  assign out_res_den    = out_den_r;
  assign out_degenerate = out_deg_r;

  a_ready_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !red_stat.busy)
    else $error("input ready while reduction unit busy");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    red_start |-> !red_stat.busy)
    else $error("reduction started while busy");

  a_done_in_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    red_stat.done |-> state_r == S_REDUCE)
    else $error("reduction done outside wait state");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_res_num == '0 && out_res_den == '0))
    else $error("degenerate result is not 0/0");

endmodule
